@@ hdl/cda_pkg.sv @@
package cda_pkg;

	// request command codes
	localparam logic [1:0] CMD_ADD_DAYS   = 2'd0;
	localparam logic [1:0] CMD_ADD_MONTHS = 2'd1;
	localparam logic [1:0] CMD_ADD_YEARS  = 2'd2;
	localparam logic [1:0] CMD_NONE       = 2'd3;

	localparam logic [13:0] YEAR_LAST  = 14'd9999;
	localparam logic [13:0] YEAR_CYCLE = 14'd400;
	localparam logic [3:0]  MONTH_LAST = 4'd12;

	localparam logic [4:0] MONTH_LEN [0:12] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic set_year;
		logic mod_step;
		logic walk_step;
		logic clamp;
		logic finish;
	} dp_cmd_t;

	// status from the datapath back to the controller
	typedef struct packed {
		logic [1:0] op;
		logic       bad;
		logic       div_last;
		logic       year_ok;
		logic       mod_done;
		logic       walk_done;
		logic       out_free;
	} dp_sts_t;

	// leap test on the year reduced modulo 400
	function automatic logic is_leap(input logic [8:0] r400);
		logic by4;
		logic century;
		by4     = (r400[1:0] == 2'd0);
		century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
		return by4 && !century;
	endfunction

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic lp);
		logic [4:0] len;
		if (m == 4'd2 && lp)
			len = 5'd29;
		else if (m >= 4'd1 && m <= MONTH_LAST)
			len = MONTH_LEN[m];
		else
			len = 5'd30;
		return len;
	endfunction

endpackage

@@ hdl/calendar_date_adder.sv @@
// Gregorian date adder. A request carries a date (start_year, start_month,
// start_day), a command (add days, add months, add years) and a signed amount;
// the block returns one result date per request. Adding days walks month by
// month with leap-year month lengths, forward or backward, so a start day
// beyond the month, or zero, is normalized by the walk. Adding months or years
// wraps months into years and clamps the day to the target month's length.
// If the start year is outside 1..9999, the start month outside 1..12, or the
// result year leaves 1..9999, out_of_range is set and the start date is
// echoed. An unused command echoes the date with out_of_range clear.
// One request is in work at a time. After acceptance, add days passes route,
// the reduction of the year modulo 400 and a walk over each month boundary
// crossed; add months passes route, the division of the month index by twelve
// (quotient, then remainder), the year update, the same reduction and the day
// clamp; add years passes route, the year update, the reduction and the clamp;
// a bad start date or the unused command goes from route to done. The month
// walk dominates add days. A finished result sits in an output register, so
// a new request may be taken while it waits.
module calendar_date_adder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         command,
	input  logic [13:0]        start_year,
	input  logic [3:0]         start_month,
	input  logic [4:0]         start_day,
	input  logic signed [15:0] amount,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [13:0]        result_year,
	output logic [3:0]         result_month,
	output logic [4:0]         result_day,
	output logic               out_of_range
);
	import cda_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// sequence the request through route, divide, reduce, walk or clamp
	cda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	// hold the date, the divider, the mod-400 year and the result register
	cda_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.sts          (dp_sts),
		.command      (command),
		.start_year   (start_year),
		.start_month  (start_month),
		.start_day    (start_day),
		.amount       (amount),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.result_year  (result_year),
		.result_month (result_month),
		.result_day   (result_day),
		.out_of_range (out_of_range)
	);

endmodule

@@ hdl/cda_ctrl.sv @@
module cda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  cda_pkg::dp_sts_t  sts,
	output cda_pkg::dp_cmd_t  cmd
);
	import cda_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROUTE = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_YEAR  = 3'd3;
	localparam logic [2:0] S_MOD   = 3'd4;
	localparam logic [2:0] S_WALK  = 3'd5;
	localparam logic [2:0] S_CLAMP = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ROUTE;
				end
			end
			S_ROUTE: begin
				if (sts.bad || sts.op == CMD_NONE)
					state_d = S_DONE;
				else if (sts.op == CMD_ADD_DAYS)
					state_d = S_MOD;
				else if (sts.op == CMD_ADD_MONTHS)
					state_d = S_DIV;
				else
					state_d = S_YEAR;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = S_YEAR;
			end
			S_YEAR: begin
				cmd.set_year = 1'b1;
				state_d = sts.year_ok ? S_MOD : S_DONE;
			end
			S_MOD: begin
				if (sts.mod_done)
					state_d = (sts.op == CMD_ADD_DAYS) ? S_WALK : S_CLAMP;
				else
					cmd.mod_step = 1'b1;
			end
			S_WALK: begin
				if (sts.walk_done)
					state_d = S_DONE;
				else
					cmd.walk_step = 1'b1;
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

@@ hdl/cda_dp.sv @@
module cda_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  cda_pkg::dp_cmd_t  cmd,
	output cda_pkg::dp_sts_t  sts,
	input  logic [1:0]        command,
	input  logic [13:0]       start_year,
	input  logic [3:0]        start_month,
	input  logic [4:0]        start_day,
	input  logic signed [15:0] amount,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [13:0]       result_year,
	output logic [3:0]        result_month,
	output logic [4:0]        result_day,
	output logic              out_of_range
);
	import cda_pkg::*;

	localparam logic [15:0] DIVISOR  = 16'd12;
	// ceil(2^19 / 12); exact quotient for any index magnitude below 2^16 / 2
	localparam logic [15:0] RECIP_12 = 16'd43691;

	// held request
	logic [1:0]          op_q;
	logic [13:0]         y0_q;
	logic [3:0]          m0_q;
	logic [4:0]          d0_q;
	logic signed [15:0]  amt_q;
	logic                bad_q;

	// working date
	logic signed [14:0]  yr_q;
	logic [3:0]          mo_q;
	logic signed [16:0]  dy_q;
	logic [13:0]         m400_q;

	// month index division by twelve: quotient first, remainder next cycle
	logic [15:0]         rem_q;
	logic [11:0]         quo_q;
	logic                div_ph_q;
	logic                neg_q;

	// result register
	logic                res_valid_q;
	logic [13:0]         res_year_q;
	logic [3:0]          res_month_q;
	logic [4:0]          res_day_q;
	logic                res_oor_q;

	logic                in_bad;
	logic signed [16:0]  idx;
	logic signed [16:0]  dy_load;
	logic [11:0]         quo_est;
	logic [15:0]         quo_x12;
	logic signed [12:0]  q_s;
	logic [3:0]          r_m;
	logic signed [16:0]  y0_ext;
	logic signed [16:0]  yt;
	logic                leap;
	logic [4:0]          dim_cur;
	logic [4:0]          dim_prev;
	logic [4:0]          d_lo;
	logic                fwd;
	logic                back;
	logic                yr_bad;

	assign in_bad = (start_year == 14'd0) || (start_year > YEAR_LAST) ||
		(start_month == 4'd0) || (start_month > MONTH_LAST);
	assign idx = $signed({13'd0, start_month}) - 17'sd1 + $signed({amount[15], amount});
	assign dy_load = $signed({12'd0, start_day}) + $signed({amount[15], amount});
	assign quo_est = 12'(({16'd0, rem_q} * {16'd0, RECIP_12}) >> 19);
	assign quo_x12 = {2'd0, quo_q, 2'd0} + {1'b0, quo_q, 3'd0};

	// floor division fixup for a negative month index
	always_comb begin
		if (neg_q && rem_q != 16'd0) begin
			q_s = -$signed({1'b0, quo_q}) - 13'sd1;
			r_m = 4'(16'd12 - rem_q);
		end else if (neg_q) begin
			q_s = -$signed({1'b0, quo_q});
			r_m = 4'd0;
		end else begin
			q_s = $signed({1'b0, quo_q});
			r_m = rem_q[3:0];
		end
	end

	assign y0_ext = $signed({3'd0, y0_q});
	assign yt = (op_q == CMD_ADD_MONTHS) ?
		y0_ext + $signed({{4{q_s[12]}}, q_s}) :
		y0_ext + $signed({amt_q[15], amt_q});

	assign leap     = is_leap(m400_q[8:0]);
	assign dim_cur  = days_in(mo_q, leap);
	assign dim_prev = (mo_q == 4'd1) ? 5'd31 : days_in(mo_q - 4'd1, leap);
	assign d_lo     = (d0_q == 5'd0) ? 5'd1 : d0_q;
	assign fwd      = dy_q > $signed({12'd0, dim_cur});
	assign back     = dy_q < 17'sd1;
	assign yr_bad   = (yr_q < 15'sd1) || (yr_q > 15'sd9999);

	assign sts.op        = op_q;
	assign sts.bad       = bad_q;
	assign sts.div_last  = div_ph_q;
	assign sts.year_ok   = (yt >= 17'sd1) && (yt <= 17'sd9999);
	assign sts.mod_done  = (m400_q < YEAR_CYCLE);
	assign sts.walk_done = !fwd && !back;
	assign sts.out_free  = !res_valid_q || res_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= command;
			y0_q     <= start_year;
			m0_q     <= start_month;
			d0_q     <= start_day;
			amt_q    <= amount;
			bad_q    <= in_bad;
			yr_q     <= $signed({1'b0, start_year});
			mo_q     <= start_month;
			dy_q     <= (command == CMD_ADD_DAYS) ? dy_load : $signed({12'd0, start_day});
			m400_q   <= start_year;
			neg_q    <= idx[16];
			rem_q    <= idx[16] ? 16'(-idx) : idx[15:0];
			quo_q    <= '0;
			div_ph_q <= 1'b0;
		end
		if (cmd.div_step) begin
			if (!div_ph_q)
				quo_q <= quo_est;
			else
				rem_q <= rem_q - quo_x12;
			div_ph_q <= 1'b1;
		end
		if (cmd.set_year) begin
			if (sts.year_ok) begin
				yr_q   <= yt[14:0];
				m400_q <= yt[13:0];
				if (op_q == CMD_ADD_MONTHS)
					mo_q <= r_m + 4'd1;
			end else begin
				bad_q <= 1'b1;
			end
		end
		if (cmd.mod_step)
			m400_q <= m400_q - YEAR_CYCLE;
		if (cmd.walk_step) begin
			if (fwd) begin
				dy_q <= dy_q - $signed({12'd0, dim_cur});
				if (mo_q == MONTH_LAST) begin
					mo_q   <= 4'd1;
					yr_q   <= yr_q + 15'sd1;
					m400_q <= (m400_q == YEAR_CYCLE - 14'd1) ? 14'd0 : m400_q + 14'd1;
				end else begin
					mo_q <= mo_q + 4'd1;
				end
			end else begin
				dy_q <= dy_q + $signed({12'd0, dim_prev});
				if (mo_q == 4'd1) begin
					mo_q   <= MONTH_LAST;
					yr_q   <= yr_q - 15'sd1;
					m400_q <= (m400_q == 14'd0) ? YEAR_CYCLE - 14'd1 : m400_q - 14'd1;
				end else begin
					mo_q <= mo_q - 4'd1;
				end
			end
		end
		if (cmd.clamp)
			dy_q <= $signed({12'd0, (d_lo > dim_cur) ? dim_cur : d_lo});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.finish)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (bad_q || yr_bad) begin
				res_year_q  <= y0_q;
				res_month_q <= m0_q;
				res_day_q   <= d0_q;
				res_oor_q   <= 1'b1;
			end else begin
				res_year_q  <= yr_q[13:0];
				res_month_q <= mo_q;
				res_day_q   <= dy_q[4:0];
				res_oor_q   <= 1'b0;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign result_year  = res_year_q;
	assign result_month = res_month_q;
	assign result_day   = res_day_q;
	assign out_of_range = res_oor_q;

	a_walk_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> m400_q < YEAR_CYCLE)
		else $error("month walk started before year reduction finished");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!res_valid_q || res_ready))
		else $error("result overwritten before it was taken");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_year && op_q == CMD_ADD_MONTHS |-> rem_q < DIVISOR)
		else $error("month index remainder not below twelve");

	a_year_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_oor_q |-> res_year_q >= 14'd1 && res_year_q <= YEAR_LAST)
		else $error("in-range result carries a year outside 1..9999");

	a_date_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_oor_q |->
		res_month_q >= 4'd1 && res_month_q <= MONTH_LAST)
		else $error("in-range result carries a bad month");

endmodule

@@ bench/tb_calendar_date_adder.sv @@
`timescale 1ns / 100ps

module tb_calendar_date_adder;
	import cda_pkg::*;

	// Clock half period, reset length and the largest idle burst on each channel
	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 6;
	localparam int BURST_MAX     = 17;
	// Receiver hold-off for the pressure test, long enough to back the block up
	localparam int LONG_STALL    = 300;
	// Worst add-days walk is roughly 1080 month steps plus the year reduction
	localparam int SETTLE_CYCLES = 1200;
	// Limit on the whole run, set well above the slowest legal run
	localparam int RUN_LIMIT_NS  = 40_000_000;
	localparam int RANDOM_ITEMS  = 480;
	localparam int STEADY_ITEMS  = 30;
	localparam int FIRST_YEAR    = 1;
	localparam int LAST_YEAR     = 9999;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        out_of_range;
	} date_result_t;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	logic [1:0]         command;
	logic [13:0]        start_year;
	logic [3:0]         start_month;
	logic [4:0]         start_day;
	logic signed [15:0] amount;
	logic               res_valid;
	logic               res_ready;
	logic [13:0]        result_year;
	logic [3:0]         result_month;
	logic [4:0]         result_day;
	logic               out_of_range;

	// Dates predicted for accepted requests, oldest first
	date_result_t pending_dates[$];
	date_result_t head_date;

	int  requests_sent;
	int  results_checked;
	int  range_flags_seen;
	int  errors_seen;
	// Set by a test to ask the receiver for one long hold-off; cleared by the receiver
	bit  long_stall_req;
	// No idling on either channel while set
	bit  steady;

	calendar_date_adder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.command      (command),
		.start_year   (start_year),
		.start_month  (start_month),
		.start_day    (start_day),
		.amount       (amount),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.result_year  (result_year),
		.result_month (result_month),
		.result_day   (result_day),
		.out_of_range (out_of_range)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// ---------------------------------------------------------------
	// Date arithmetic
	// ---------------------------------------------------------------

	// Gregorian rule: every 4th year, except centuries not divisible by 400
	function automatic bit leap_year(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// Length of month m in year y; a month outside 1..12 counts as 30 days
	function automatic int month_days(input int y, input int m);
		if (m < 1 || m > 12)
			return 30;
		if (m == 2)
			return leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	// Pull a day into 1..length of the target month
	function automatic int fit_day(input int y, input int m, input int d);
		int top;
		top = month_days(y, m);
		if (d > top)
			return top;
		if (d < 1)
			return 1;
		return d;
	endfunction

	// Predict the block's answer for one request
	function automatic date_result_t add_to_date(input logic [1:0] cmd,
			input logic [13:0] y0, input logic [3:0] m0, input logic [4:0] d0,
			input logic signed [15:0] amt);
		date_result_t res;
		int y, m, d, steps, idx, q, rem;
		bit bad;
		y     = int'(y0);
		m     = int'(m0);
		d     = int'(d0);
		steps = int'(amt);
		bad   = (y < FIRST_YEAR) || (y > LAST_YEAR) || (m < 1) || (m > 12);
		if (!bad) begin
			case (cmd)
				CMD_ADD_DAYS: begin
					// walk whole months forward, then backward, until the day fits
					d = d + steps;
					while (d > month_days(y, m)) begin
						d -= month_days(y, m);
						m++;
						if (m > 12) begin
							m = 1;
							y++;
						end
					end
					while (d < 1) begin
						m--;
						if (m < 1) begin
							m = 12;
							y--;
						end
						d += month_days(y, m);
					end
				end
				CMD_ADD_MONTHS: begin
					// floor division of the month index into years
					idx = (m - 1) + steps;
					q   = idx / 12;
					rem = idx % 12;
					if (rem < 0) begin
						rem += 12;
						q--;
					end
					y = y + q;
					m = rem + 1;
					if (y >= FIRST_YEAR && y <= LAST_YEAR)
						d = fit_day(y, m, d);
				end
				CMD_ADD_YEARS: begin
					y = y + steps;
					if (y >= FIRST_YEAR && y <= LAST_YEAR)
						d = fit_day(y, m, d);
				end
				default: ;
			endcase
			bad = (y < FIRST_YEAR) || (y > LAST_YEAR);
		end
		// a rejected request echoes its own date
		if (bad) begin
			y = int'(y0);
			m = int'(m0);
			d = int'(d0);
		end
		res.year         = y[13:0];
		res.month        = m[3:0];
		res.day          = d[4:0];
		res.out_of_range = bad;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------

	// Offer one request and hold it until accepted. Entered and left at a falling
	// edge; valid stays high on return so the next call can follow back to back.
	task automatic send_request(input logic [1:0] cmd, input logic [13:0] y,
			input logic [3:0] m, input logic [4:0] d, input logic signed [15:0] amt);
		date_result_t predicted;
		predicted = add_to_date(cmd, y, m, d, amt);
		if (!steady && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, BURST_MAX)) @(negedge clk);
		end
		req_valid   <= 1'b1;
		command     <= cmd;
		start_year  <= y;
		start_month <= m;
		start_day   <= d;
		amount      <= amt;
		do
			@(posedge clk);
		while (!req_ready);
		pending_dates.push_back(predicted);
		requests_sent++;
		@(negedge clk);
	endtask

	// Draw one request: mostly legal dates, with edge years, bad fields and
	// the unused command mixed in. Day walks mostly stay short.
	task automatic send_random_request();
		logic [1:0]         cmd;
		logic [13:0]        y;
		logic [3:0]         m;
		logic [4:0]         d;
		logic signed [15:0] amt;
		int                 pick;
		int                 size_pick;
		pick = $urandom_range(0, 19);
		if (pick < 6)
			cmd = CMD_ADD_DAYS;
		else if (pick < 12)
			cmd = CMD_ADD_MONTHS;
		else if (pick < 18)
			cmd = CMD_ADD_YEARS;
		else
			cmd = CMD_NONE;

		pick = $urandom_range(0, 15);
		if (pick == 0)
			y = 14'($urandom_range(0, 16383));
		else if (pick == 1)
			y = 14'($urandom_range(1, 3));
		else if (pick == 2)
			y = 14'($urandom_range(9997, 9999));
		else
			y = 14'($urandom_range(1, 9999));

		if ($urandom_range(0, 15) == 0)
			m = 4'($urandom_range(0, 15));
		else
			m = 4'($urandom_range(1, 12));

		if ($urandom_range(0, 3) == 0)
			d = 5'($urandom_range(0, 31));
		else
			d = 5'($urandom_range(1, month_days(int'(y), int'(m))));

		size_pick = $urandom_range(0, 9);
		case (cmd)
			CMD_ADD_DAYS: begin
				if (size_pick == 0)
					amt = 16'($urandom);
				else if (size_pick < 3)
					amt = 16'($urandom_range(0, 8000) - 4000);
				else
					amt = 16'($urandom_range(0, 800) - 400);
			end
			CMD_ADD_MONTHS: begin
				if (size_pick < 3)
					amt = 16'($urandom);
				else
					amt = 16'($urandom_range(0, 2400) - 1200);
			end
			CMD_ADD_YEARS: begin
				if (size_pick < 2)
					amt = 16'($urandom);
				else if (size_pick < 4)
					amt = 16'($urandom_range(0, 24000) - 12000);
				else
					amt = 16'($urandom_range(0, 600) - 300);
			end
			default: amt = 16'($urandom);
		endcase
		send_request(cmd, y, m, d, amt);
	endtask

	// ---------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------

	// Receiver: random hold-off bursts, one long hold-off on request, none in steady mode
	initial begin
		res_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_stall_req) begin
				res_ready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				long_stall_req = 1'b0;
				res_ready <= 1'b1;
			end else if (!steady && $urandom_range(0, 11) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, BURST_MAX)) @(negedge clk);
				res_ready <= 1'b1;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_dates.size() == 0) begin
				$error("result %0d-%0d-%0d (out_of_range %0b) with no request outstanding",
					result_year, result_month, result_day, out_of_range);
				errors_seen++;
			end else begin
				head_date = pending_dates.pop_front();
				results_checked++;
				if (out_of_range)
					range_flags_seen++;
				if (result_year !== head_date.year) begin
					$error("result_year: expected %0d, got %0d", head_date.year, result_year);
					errors_seen++;
				end
				if (result_month !== head_date.month) begin
					$error("result_month: expected %0d, got %0d",
						head_date.month, result_month);
					errors_seen++;
				end
				if (result_day !== head_date.day) begin
					$error("result_day: expected %0d, got %0d", head_date.day, result_day);
					errors_seen++;
				end
				if (out_of_range !== head_date.out_of_range) begin
					$error("out_of_range: expected %0b, got %0b",
						head_date.out_of_range, out_of_range);
					errors_seen++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Day walks across month, leap and year boundaries, and off both ends of the calendar
	task automatic test_day_walk();
		send_request(CMD_ADD_DAYS, 14'd2000, 4'd2, 5'd28, 16'sd1);
		send_request(CMD_ADD_DAYS, 14'd1900, 4'd2, 5'd28, 16'sd1);
		send_request(CMD_ADD_DAYS, 14'd9999, 4'd12, 5'd31, 16'sd1);
		send_request(CMD_ADD_DAYS, 14'd1, 4'd1, 5'd1, -16'sd1);
		// day zero normalizes to the end of the previous month
		send_request(CMD_ADD_DAYS, 14'd2024, 4'd3, 5'd0, 16'sd0);
		// a day past the month's end rolls into the next month
		send_request(CMD_ADD_DAYS, 14'd2023, 4'd2, 5'd31, 16'sd0);
		send_request(CMD_ADD_DAYS, 14'd5000, 4'd6, 5'd15, 16'sh7FFF);
		send_request(CMD_ADD_DAYS, 14'd5000, 4'd6, 5'd15, 16'sh8000);
	endtask

	// Month shifts: clamping at short months, extreme amounts, year underflow
	task automatic test_month_shift();
		send_request(CMD_ADD_MONTHS, 14'd2023, 4'd1, 5'd31, 16'sd1);
		send_request(CMD_ADD_MONTHS, 14'd2024, 4'd1, 5'd31, 16'sd1);
		send_request(CMD_ADD_MONTHS, 14'd5000, 4'd7, 5'd0, -16'sd1);
		send_request(CMD_ADD_MONTHS, 14'd5000, 4'd12, 5'd31, 16'sh7FFF);
		send_request(CMD_ADD_MONTHS, 14'd9999, 4'd12, 5'd31, 16'sh8000);
		send_request(CMD_ADD_MONTHS, 14'd1, 4'd1, 5'd15, -16'sd1);
	endtask

	// Year shifts: Feb 29 into common and leap years, exact calendar ends, overflow and underflow
	task automatic test_year_shift();
		send_request(CMD_ADD_YEARS, 14'd2000, 4'd2, 5'd29, 16'sd1);
		send_request(CMD_ADD_YEARS, 14'd2000, 4'd2, 5'd29, 16'sd4);
		send_request(CMD_ADD_YEARS, 14'd1, 4'd6, 5'd30, 16'sd9998);
		send_request(CMD_ADD_YEARS, 14'd9999, 4'd6, 5'd30, -16'sd9998);
		send_request(CMD_ADD_YEARS, 14'd100, 4'd3, 5'd3, 16'sh7FFF);
		send_request(CMD_ADD_YEARS, 14'd9000, 4'd3, 5'd3, 16'sh8000);
	endtask

	// Illegal start year or month, and the unused command code
	task automatic test_bad_dates();
		send_request(CMD_ADD_DAYS, 14'd0, 4'd5, 5'd5, 16'sd1);
		send_request(CMD_ADD_MONTHS, 14'h3FFF, 4'd15, 5'd31, -16'sd1);
		send_request(CMD_ADD_YEARS, 14'd2000, 4'd0, 5'd10, 16'sd1);
		send_request(CMD_ADD_DAYS, 14'd2000, 4'd13, 5'd10, 16'sd0);
		send_request(CMD_NONE, 14'd2024, 4'd2, 5'd31, 16'sh8000);
	endtask

	// Hold the result side off while requests keep coming, so the input stalls
	task automatic test_output_stall();
		long_stall_req = 1'b1;
		repeat (12)
			send_request(CMD_ADD_YEARS, 14'($urandom_range(1, 9999)),
				4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
				16'($urandom_range(0, 20) - 10));
	endtask

	task automatic test_random_mix();
		repeat (RANDOM_ITEMS)
			send_random_request();
	endtask

	// Back-to-back traffic with no idling on either channel
	task automatic test_steady_stream();
		steady = 1'b1;
		repeat (STEADY_ITEMS)
			send_random_request();
	endtask

	// ---------------------------------------------------------------
	// Sequencing
	// ---------------------------------------------------------------

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		command        = CMD_ADD_DAYS;
		start_year     = '0;
		start_month    = '0;
		start_day      = '0;
		amount         = '0;
		long_stall_req = 1'b0;
		steady         = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_day_walk();
		test_month_shift();
		test_year_shift();
		test_bad_dates();
		test_output_stall();
		test_random_mix();
		test_steady_stream();

		// drop the request line, let every result come back, then let the block settle
		req_valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Sent %0d requests over all commands, bad dates and calendar ends;",
			requests_sent);
		$display("checked %0d results, %0d flagged out of range, with a %0d-cycle output stall.",
			results_checked, range_flags_seen, LONG_STALL);
		if (errors_seen == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog for a hung handshake
	initial begin
		#RUN_LIMIT_NS;
		$display("Timeout with %0d results still outstanding", pending_dates.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
hdl/cda_pkg.sv
hdl/cda_ctrl.sv
hdl/cda_dp.sv
hdl/calendar_date_adder.sv
bench/tb_calendar_date_adder.sv
